>>> sv/julsd_pkg.sv
// ----------------------------------------------------------------------------
// julsd_pkg: shared types and constants
// Fixed-point format, sequencer states and register indexes for the Julia
// slice distance block.
// ----------------------------------------------------------------------------
package julsd_pkg;

    localparam int FRAC_BITS = 24;          // fraction bits of Q8.24
    localparam int MAX_DEPTH = 64;          // whole iterations saturate at MAX_DEPTH-1
    localparam int DATA_W    = 32;          // coordinate and result width
    localparam int DEPTH_W   = 6;           // depth_int width
    localparam int FRAC_W    = 16;          // depth_frac width, Q0.16
    localparam int LIMIT_W   = 31;          // limit register width
    localparam int CNT_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int MUL_W     = DATA_W + 1;  // shared multiplier operand width
    localparam int PROD_W    = 2 * DATA_W;  // kept product width
    localparam int NEW_W     = PROD_W - FRAC_BITS + 2; // width of a new re/im before range check
    localparam int ROOT_W    = DATA_W;      // square root result width
    localparam int ROOT_CNT_W = $clog2(ROOT_W);
    localparam int ADDR_W    = 4;

    localparam logic [DATA_W-1:0] DIST_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    localparam logic [1:0] REG_CONST_RE = 2'd0;
    localparam logic [1:0] REG_CONST_IM = 2'd1;
    localparam logic [1:0] REG_LIMIT    = 2'd2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(33554432);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_XX,
        S_MUL_YY,
        S_MUL_XY,
        S_UPDATE,
        S_BLEND_RE,
        S_BLEND_IM,
        S_SQUARE_RE,
        S_SQUARE_IM,
        S_SUM,
        S_ROOT_START,
        S_ROOT_WAIT,
        S_FINISH
    } state_t;

endpackage

>>> sv/julsd_in_if.sv
// ----------------------------------------------------------------------------
// julsd_in_if: input point channel
// Valid/ready channel that carries one point and its depth.
// ----------------------------------------------------------------------------
interface julsd_in_if;
    import julsd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  point_x;
    logic signed [DATA_W-1:0]  point_y;
    logic [DEPTH_W-1:0]        depth_int;
    logic [FRAC_W-1:0]         depth_frac;

    modport source (output valid, point_x, point_y, depth_int, depth_frac, input ready);
    modport sink   (input valid, point_x, point_y, depth_int, depth_frac, output ready);
endinterface

>>> sv/julsd_out_if.sv
// ----------------------------------------------------------------------------
// julsd_out_if: distance result channel
// Valid/ready channel that carries one distance and its overflow flag.
// ----------------------------------------------------------------------------
interface julsd_out_if;
    import julsd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  distance;
    logic                      overflow;

    modport source (output valid, distance, overflow, input ready);
    modport sink   (input valid, distance, overflow, output ready);
endinterface

>>> sv/julsd_mul.sv
// ----------------------------------------------------------------------------
// julsd_mul: shared signed multiplier
// One registered signed multiply per cycle; the product appears in the cycle
// after the operands.
// ----------------------------------------------------------------------------
module julsd_mul
(
    input  logic                                   clk,
    input  logic signed [julsd_pkg::MUL_W-1:0]     a,
    input  logic signed [julsd_pkg::MUL_W-1:0]     b,
    output logic signed [julsd_pkg::PROD_W-1:0]    product
);
    import julsd_pkg::*;

    logic signed [PROD_W-1:0] product_reg;
    logic signed [PROD_W-1:0] product_next;

    assign product_next = PROD_W'(a * b);

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
    end

    assign product = product_reg;
endmodule

>>> sv/julsd_isqrt.sv
// ----------------------------------------------------------------------------
// julsd_isqrt: iterative integer square root
// Restoring digit-by-digit floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module julsd_isqrt
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [julsd_pkg::PROD_W-1:0]      radicand,
    output logic                              done,
    output logic [julsd_pkg::ROOT_W-1:0]      root
);
    import julsd_pkg::*;

    localparam int REM_W = ROOT_W + 2;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [ROOT_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0]      rad_reg, rad_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [ROOT_W-1:0]      root_reg, root_next;

    logic [REM_W+1:0]       rem_shift;
    logic [REM_W+1:0]       trial;

    always_comb
    begin
        rem_shift = {rem_reg, rad_reg[PROD_W-1 -: 2]};
        trial     = (REM_W + 2)'({root_reg, 2'b01});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[PROD_W-3:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_next  = REM_W'(rem_shift - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(rem_shift);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ROOT_CNT_W'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

>>> sv/julia_slice_distance_top.sv
// ----------------------------------------------------------------------------
// julia_slice_distance_top: distance to a depth slice of a Julia set
// Iterates z = z*z + c from the input point, blends two successive values and
// returns the blended magnitude minus a configured limit, in signed Q8.24.
// ----------------------------------------------------------------------------
// Iteration: z is updated n+1 times, n = min(depth_int, MAX_DEPTH-1);
//   an overflow cuts the iteration short.
//   Each iteration is four states around the one shared multiplier; the blend
//   and the 32-step square root follow the last iteration.
// Flow: one item at a time; ready is high only in idle.
// Reset: c = 0, limit = 2.0, no result pending.
// ----------------------------------------------------------------------------
module julia_slice_distance_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    julsd_in_if.sink                          item,
    julsd_out_if.source                       result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [julsd_pkg::ADDR_W-1:0]      paddr,
    input  logic [julsd_pkg::DATA_W-1:0]      pwdata,
    output logic [julsd_pkg::DATA_W-1:0]      prdata,
    output logic                              pready
);
    import julsd_pkg::*;

    // Configuration registers
    logic signed [DATA_W-1:0] const_re_reg;
    logic signed [DATA_W-1:0] const_im_reg;
    logic [LIMIT_W-1:0]       limit_reg;
    logic                     cfg_write;

    // Sequencer and datapath registers
    state_t                   state_reg, state_next;
    logic signed [DATA_W-1:0] re_reg, re_next;
    logic signed [DATA_W-1:0] im_reg, im_next;
    logic signed [DATA_W-1:0] start_re_reg, start_re_next;
    logic signed [DATA_W-1:0] start_im_reg, start_im_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [DATA_W-1:0] mid_re_reg, mid_re_next;
    logic signed [DATA_W-1:0] mid_im_reg, mid_im_next;
    logic [PROD_W-1:0]        sum_reg, sum_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     last_reg, last_next;
    logic [FRAC_W-1:0]        frac_reg, frac_next;
    logic signed [DATA_W-1:0] dist_reg, dist_next;
    logic                     ovf_reg, ovf_next;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_dist_reg, out_dist_next;
    logic                     out_ovf_reg, out_ovf_next;

    // Shared units
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] product;
    logic                     root_start;
    logic                     root_done;
    logic [ROOT_W-1:0]        root;

    // Update step terms
    logic signed [NEW_W-1:0]  re_new;
    logic signed [NEW_W-1:0]  im_new;
    logic                     re_fits;
    logic                     im_fits;
    logic [CNT_W-1:0]         depth_sat;
    logic signed [MUL_W-1:0]  frac_op;

    julsd_mul u_mul
    (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    julsd_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (sum_reg),
        .done     (root_done),
        .root     (root)
    );

    // ------------------------------------------------------------------
    // Configuration port: write on the access cycle, no wait states
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            const_re_reg <= '0;
            const_im_reg <= '0;
            limit_reg    <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_CONST_RE: const_re_reg <= pwdata;
                REG_CONST_IM: const_im_reg <= pwdata;
                REG_LIMIT:    limit_reg    <= pwdata[LIMIT_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_CONST_RE: prdata = const_re_reg;
            REG_CONST_IM: prdata = const_im_reg;
            REG_LIMIT:    prdata = DATA_W'(limit_reg);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Update step: the multiplier holds x*y while acc holds x*x - y*y
    // ------------------------------------------------------------------
    assign re_new  = NEW_W'(acc_reg >>> FRAC_BITS) + NEW_W'(const_re_reg);
    assign im_new  = NEW_W'(product >>> (FRAC_BITS - 1)) + NEW_W'(const_im_reg);
    assign re_fits = (&re_new[NEW_W-1:DATA_W-1]) || !(|re_new[NEW_W-1:DATA_W-1]);
    assign im_fits = (&im_new[NEW_W-1:DATA_W-1]) || !(|im_new[NEW_W-1:DATA_W-1]);

    // Saturate the whole-iteration count
    assign depth_sat = (32'(item.depth_int) > 32'(MAX_DEPTH - 1))
                     ? CNT_W'(MAX_DEPTH - 1) : CNT_W'(item.depth_int);
    assign frac_op   = MUL_W'(signed'({1'b0, frac_reg}));

    assign item.ready      = (state_reg == S_IDLE);
    assign result.valid    = out_valid_reg;
    assign result.distance = out_dist_reg;
    assign result.overflow = out_ovf_reg;

    // ------------------------------------------------------------------
    // Sequencer: next state, operand selection and datapath updates
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        re_next        = re_reg;
        im_next        = im_reg;
        start_re_next  = start_re_reg;
        start_im_next  = start_im_reg;
        acc_next       = acc_reg;
        mid_re_next    = mid_re_reg;
        mid_im_next    = mid_im_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        frac_next      = frac_reg;
        dist_next      = dist_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        out_dist_next  = out_dist_reg;
        out_ovf_next   = out_ovf_reg;
        mul_a          = MUL_W'(re_reg);
        mul_b          = MUL_W'(re_reg);
        root_start     = 1'b0;

        // Drop the result once the sink takes it
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    re_next       = item.point_x;
                    im_next       = item.point_y;
                    start_re_next = item.point_x;
                    start_im_next = item.point_y;
                    frac_next     = item.depth_frac;
                    cnt_next      = depth_sat;
                    last_next     = (depth_sat == '0);
                    ovf_next      = 1'b0;
                    state_next    = S_MUL_XX;
                end
            end
            S_MUL_XX:
            begin
                state_next = S_MUL_YY;
            end
            S_MUL_YY:
            begin
                mul_a      = MUL_W'(im_reg);
                mul_b      = MUL_W'(im_reg);
                acc_next   = product;
                state_next = S_MUL_XY;
            end
            S_MUL_XY:
            begin
                mul_a      = MUL_W'(re_reg);
                mul_b      = MUL_W'(im_reg);
                acc_next   = PROD_W'(acc_reg - product);
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (!re_fits || !im_fits)
                begin
                    ovf_next   = 1'b1;
                    dist_next  = DIST_MAX;
                    state_next = S_FINISH;
                end
                else
                begin
                    re_next = re_new[DATA_W-1:0];
                    im_next = im_new[DATA_W-1:0];
                    if (last_reg)
                    begin
                        state_next = S_BLEND_RE;
                    end
                    else
                    begin
                        // Hold the value of the last whole iteration as start
                        cnt_next = cnt_reg - 1'b1;
                        if (cnt_reg == CNT_W'(1))
                        begin
                            start_re_next = re_new[DATA_W-1:0];
                            start_im_next = im_new[DATA_W-1:0];
                            last_next     = 1'b1;
                        end
                        state_next = S_MUL_XX;
                    end
                end
            end
            S_BLEND_RE:
            begin
                mul_a      = frac_op;
                mul_b      = MUL_W'(re_reg) - MUL_W'(start_re_reg);
                state_next = S_BLEND_IM;
            end
            S_BLEND_IM:
            begin
                mul_a       = frac_op;
                mul_b       = MUL_W'(im_reg) - MUL_W'(start_im_reg);
                mid_re_next = start_re_reg + DATA_W'(product >>> FRAC_W);
                state_next  = S_SQUARE_RE;
            end
            S_SQUARE_RE:
            begin
                mul_a       = MUL_W'(mid_re_reg);
                mul_b       = MUL_W'(mid_re_reg);
                mid_im_next = start_im_reg + DATA_W'(product >>> FRAC_W);
                state_next  = S_SQUARE_IM;
            end
            S_SQUARE_IM:
            begin
                mul_a      = MUL_W'(mid_im_reg);
                mul_b      = MUL_W'(mid_im_reg);
                sum_next   = unsigned'(product);
                state_next = S_SUM;
            end
            S_SUM:
            begin
                sum_next   = PROD_W'(sum_reg + unsigned'(product));
                state_next = S_ROOT_START;
            end
            S_ROOT_START:
            begin
                root_start = 1'b1;
                state_next = S_ROOT_WAIT;
            end
            S_ROOT_WAIT:
            begin
                if (root_done)
                begin
                    if (root[ROOT_W-1])
                    begin
                        ovf_next  = 1'b1;
                        dist_next = DIST_MAX;
                    end
                    else
                    begin
                        dist_next = DATA_W'(root[DATA_W-2:0]) - DATA_W'(limit_reg);
                    end
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // Advance once the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_dist_next  = dist_reg;
                    out_ovf_next   = ovf_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        re_reg       <= re_next;
        im_reg       <= im_next;
        start_re_reg <= start_re_next;
        start_im_reg <= start_im_next;
        acc_reg      <= acc_next;
        mid_re_reg   <= mid_re_next;
        mid_im_reg   <= mid_im_next;
        sum_reg      <= sum_next;
        cnt_reg      <= cnt_next;
        last_reg     <= last_next;
        frac_reg     <= frac_next;
        dist_reg     <= dist_next;
        ovf_reg      <= ovf_next;
        out_dist_reg <= out_dist_next;
        out_ovf_reg  <= out_ovf_next;
    end
endmodule

>>> sv/julsd_check.sv
// ----------------------------------------------------------------------------
// julsd_check: port-level checks
// Watches the item and result channels of the top level over time.
// ----------------------------------------------------------------------------
module julsd_check
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              item_valid,
    input logic                              item_ready,
    input logic                              res_valid,
    input logic                              res_ready,
    input logic [julsd_pkg::DATA_W-1:0]      res_distance,
    input logic                              res_overflow
);
    import julsd_pkg::*;

    // A pending result holds until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_distance)
                                   && $stable(res_overflow))
        else $error("result changed while stalled");

    // An overflowed result carries the saturated distance
    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_overflow |-> res_distance == DIST_MAX)
        else $error("overflow without saturated distance");

    // The block is busy in the cycle after an input transaction
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("ready right after input transaction");

    // No result can appear in the cycle after an input transaction
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !$rose(res_valid))
        else $error("result too early");
endmodule

bind julia_slice_distance_top julsd_check u_julsd_check
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_distance (result.distance),
    .res_overflow (result.overflow)
);
